FILE: design/swsd_pkg.sv
package swsd_pkg;

    localparam int WINDOW_DEF = 12;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    // largest reading in us is (2^32 - 1) / 1000, which fits in 23 bits
    localparam int SAMPLE_W   = 23;
    localparam int CNT_W      = 8;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DATA_W-1:0] TIMEOUT_RST = 32'd10000;
    localparam logic [TOL_W-1:0]  TOL_RST     = 16'd1000;

    // ns -> us divisor and floor(2^32 / 1000)
    localparam logic [DATA_W-1:0] NS_PER_US       = 32'd1000;
    localparam logic [DATA_W-1:0] RECIP_NS_PER_US = 32'd4294967;

    typedef enum logic [2:0] {
        ST_COLLECTING = 3'd0,
        ST_STABLE     = 3'd1,
        ST_UNSTABLE   = 3'd2,
        ST_TIMEOUT    = 3'd3,
        ST_FAILED     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 1'b0,
        CFG_TOLERANCE = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DMUL,
        S_DFIX,
        S_DCOR,
        S_SUM,
        S_VAR,
        S_LIM,
        S_CMP,
        S_EMIT
    } t_state;

    // which quotient the constant divider is producing
    typedef enum logic [1:0] {
        DIV_NS,
        DIV_SUM,
        DIV_VAR
    } t_div;

endpackage

FILE: design/swsd_ram.sv
module swsd_ram #(
    parameter int WIDTH = swsd_pkg::SAMPLE_W,
    parameter int DEPTH = swsd_pkg::WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/swsd_mul.sv
module swsd_mul (
    input  logic                        i_clk,
    input  logic [swsd_pkg::DATA_W-1:0] i_a,
    input  logic [swsd_pkg::DATA_W-1:0] i_b,
    output logic [swsd_pkg::PROD_W-1:0] o_prod
);

    logic [swsd_pkg::PROD_W-1:0] r_prod;

    // full 32x32 product, registered
    always_ff @(posedge i_clk) begin
        r_prod <= swsd_pkg::PROD_W'(i_a) * swsd_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: design/sliding_window_stability_detector_top.sv
// Conductivity stability detector. Each input transfer carries a reading in nS, the ms elapsed
// in the current wait and a failure flag; each one yields exactly one result transfer. A wait
// past timeout_ms reports timed out (this wins over a failed reading), a failed reading
// reports failed; both end the run and clear the sample count. Otherwise the reading is
// converted to uS and stored in a WINDOW-deep ring; while fewer than WINDOW samples are
// held the result is "collecting", afterwards the truncated mean and population variance
// (32-bit wrapping) of the window are reported, stable when the variance is below the
// squared tolerance, which also ends the run. samples_taken wraps at 256. One 32x32
// multiplier does all multiplications (divisions by constants through reciprocals, squares,
// tolerance square) and the ring has one read port, so the window is walked one sample a
// cycle, twice. Input ready is high only when the sequencer is idle; a finished result
// waits in the output register without holding up the next input transfer. Configuration
// writes take effect at once and are expected only while the block is idle.
module sliding_window_stability_detector_top #(
    parameter int WINDOW = swsd_pkg::WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [swsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [swsd_pkg::DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [swsd_pkg::DATA_W-1:0]    i_reading_ns,
    input  logic [swsd_pkg::DATA_W-1:0]    i_elapsed_ms,
    input  logic                           i_reading_failed,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [swsd_pkg::DATA_W-1:0]    o_mean_us,
    output logic [swsd_pkg::DATA_W-1:0]    o_variance_us2,
    output logic [swsd_pkg::CNT_W-1:0]     o_samples_taken
);

    localparam int DW = swsd_pkg::DATA_W;
    localparam int SW = swsd_pkg::SAMPLE_W;
    localparam int CW = swsd_pkg::CNT_W;
    localparam int AW = $clog2(WINDOW);
    localparam int IW = $clog2(WINDOW + 1);

    // floor(2^32 / WINDOW): quotient estimate is low by at most one
    localparam logic [DW-1:0] RECIP_WIN = DW'((64'd1 << 32) / WINDOW);
    localparam logic [DW-1:0] WIN_D     = DW'(WINDOW);
    localparam logic [IW-1:0] IDX_END   = IW'(WINDOW);
    localparam logic [AW-1:0] PTR_LAST  = AW'(WINDOW - 1);
    localparam logic [CW-1:0] CNT_WIN   = CW'(WINDOW);

    swsd_pkg::t_state  r_state, n_state;
    swsd_pkg::t_div    r_dk;
    swsd_pkg::t_status r_st;

    logic [DW-1:0]              r_timeout;
    logic [swsd_pkg::TOL_W-1:0] r_tol;
    logic [CW-1:0]              r_count;
    logic [AW-1:0]              r_wptr;
    logic [DW-1:0]              r_x;      // dividend
    logic [DW-1:0]              r_q;      // quotient estimate
    logic [DW-1:0]              r_acc;
    logic [DW-1:0]              r_mean;
    logic [DW-1:0]              r_var;
    logic [CW-1:0]              r_cnt_out;
    logic [IW-1:0]              r_idx;
    logic                       r_rdv;    // ring read data valid
    logic                       r_pv;     // square product valid

    logic                       r_out_valid;
    swsd_pkg::t_status          r_out_status;
    logic [DW-1:0]              r_out_mean;
    logic [DW-1:0]              r_out_var;
    logic [CW-1:0]              r_out_cnt;

    // shared unit and ring
    logic [DW-1:0]                w_mul_a, w_mul_b;
    logic [swsd_pkg::PROD_W-1:0]  w_prod;
    logic                         w_ram_we;
    logic [AW-1:0]                w_raddr;
    logic [SW-1:0]                w_rdata;

    logic          w_in_acc, w_timed_out, w_slot_free, w_idx_live, w_stable;
    logic [DW-1:0] w_div_d, w_div_r, w_prod_hi, w_div_rem, w_div_q, w_dev;
    logic [CW-1:0] w_cnt_inc;

    // ---------------------------------------------------------------- datapath helpers
    assign w_in_acc    = i_in_valid && (r_state == swsd_pkg::S_IDLE);
    assign w_timed_out = i_elapsed_ms > r_timeout;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_idx_live  = r_idx != IDX_END;
    assign w_cnt_inc   = r_count + CW'(1);

    // divide by a constant: q0 = (x * recip) >> 32, then one remainder correction
    assign w_div_d   = (r_dk == swsd_pkg::DIV_NS) ? swsd_pkg::NS_PER_US : WIN_D;
    assign w_div_r   = (r_dk == swsd_pkg::DIV_NS) ? swsd_pkg::RECIP_NS_PER_US : RECIP_WIN;
    assign w_prod_hi = w_prod[swsd_pkg::PROD_W-1:DW];
    assign w_div_rem = r_x - w_prod[DW-1:0];
    assign w_div_q   = (w_div_rem >= w_div_d) ? r_q + DW'(1) : r_q;

    assign w_dev    = DW'(w_rdata) - r_mean;
    assign w_stable = r_var < w_prod[DW-1:0];

    swsd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    swsd_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wptr),
        .i_wdata (w_div_q[SW-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swsd_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_timed_out || i_reading_failed) begin
                        n_state = swsd_pkg::S_EMIT;
                    end else begin
                        n_state = swsd_pkg::S_DMUL;
                    end
                end
            end
            swsd_pkg::S_DMUL: n_state = swsd_pkg::S_DFIX;
            swsd_pkg::S_DFIX: n_state = swsd_pkg::S_DCOR;
            swsd_pkg::S_DCOR: begin
                case (r_dk)
                    swsd_pkg::DIV_NS: begin
                        n_state = (w_cnt_inc < CNT_WIN) ? swsd_pkg::S_EMIT : swsd_pkg::S_SUM;
                    end
                    swsd_pkg::DIV_SUM: n_state = swsd_pkg::S_VAR;
                    swsd_pkg::DIV_VAR: n_state = swsd_pkg::S_LIM;
                    default:           n_state = swsd_pkg::S_IDLE;
                endcase
            end
            swsd_pkg::S_SUM: begin
                if (!w_idx_live && !r_rdv) begin
                    n_state = swsd_pkg::S_DMUL;
                end
            end
            swsd_pkg::S_VAR: begin
                if (!w_idx_live && !r_rdv && !r_pv) begin
                    n_state = swsd_pkg::S_DMUL;
                end
            end
            swsd_pkg::S_LIM: n_state = swsd_pkg::S_CMP;
            swsd_pkg::S_CMP: n_state = swsd_pkg::S_EMIT;
            swsd_pkg::S_EMIT: begin
                if (w_slot_free) begin
                    n_state = swsd_pkg::S_IDLE;
                end
            end
            default: n_state = swsd_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- sequencer outputs
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_ram_we = 1'b0;
        w_raddr  = w_idx_live ? r_idx[AW-1:0] : '0;
        case (r_state)
            swsd_pkg::S_DMUL: begin
                w_mul_a = r_x;
                w_mul_b = w_div_r;
            end
            swsd_pkg::S_DFIX: begin
                w_mul_a = w_prod_hi;
                w_mul_b = w_div_d;
            end
            swsd_pkg::S_DCOR: begin
                w_ram_we = (r_dk == swsd_pkg::DIV_NS);
            end
            swsd_pkg::S_VAR: begin
                w_mul_a = w_dev;
                w_mul_b = w_dev;
            end
            swsd_pkg::S_LIM: begin
                w_mul_a = DW'(r_tol);
                w_mul_b = DW'(r_tol);
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready = (r_state == swsd_pkg::S_IDLE);

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swsd_pkg::S_IDLE;
            r_timeout   <= swsd_pkg::TIMEOUT_RST;
            r_tol       <= swsd_pkg::TOL_RST;
            r_count     <= '0;
            r_wptr      <= '0;
            r_idx       <= '0;
            r_rdv       <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (swsd_pkg::t_cfg_reg'(i_cfg_idx))
                    swsd_pkg::CFG_TIMEOUT:   r_timeout <= i_cfg_data;
                    swsd_pkg::CFG_TOLERANCE: r_tol     <= i_cfg_data[swsd_pkg::TOL_W-1:0];
                    default: begin
                    end
                endcase
            end

            // a result loaded in S_EMIT takes the place of the one leaving
            if (r_out_valid && i_out_ready && (r_state != swsd_pkg::S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                swsd_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_mean    <= '0;
                        r_var     <= '0;
                        r_cnt_out <= r_count;
                        r_x       <= i_reading_ns;
                        r_dk      <= swsd_pkg::DIV_NS;
                        if (w_timed_out || i_reading_failed) begin
                            r_st    <= w_timed_out ? swsd_pkg::ST_TIMEOUT : swsd_pkg::ST_FAILED;
                            r_count <= '0;
                            r_wptr  <= '0;
                        end
                    end
                end
                swsd_pkg::S_DFIX: begin
                    r_q <= w_prod_hi;
                end
                swsd_pkg::S_DCOR: begin
                    r_idx <= '0;
                    r_acc <= '0;
                    case (r_dk)
                        swsd_pkg::DIV_NS: begin
                            r_count   <= w_cnt_inc;
                            r_cnt_out <= w_cnt_inc;
                            r_st      <= swsd_pkg::ST_COLLECTING;
                            // count wrapping to zero restarts the ring at entry 0
                            if (w_cnt_inc == '0 || r_wptr == PTR_LAST) begin
                                r_wptr <= '0;
                            end else begin
                                r_wptr <= r_wptr + AW'(1);
                            end
                        end
                        swsd_pkg::DIV_SUM: r_mean <= w_div_q;
                        swsd_pkg::DIV_VAR: r_var  <= w_div_q;
                        default: begin
                        end
                    endcase
                end
                swsd_pkg::S_SUM: begin
                    if (w_idx_live) begin
                        r_idx <= r_idx + IW'(1);
                    end
                    r_rdv <= w_idx_live;
                    if (r_rdv) begin
                        r_acc <= r_acc + DW'(w_rdata);
                    end
                    if (!w_idx_live && !r_rdv) begin
                        r_x  <= r_acc;
                        r_dk <= swsd_pkg::DIV_SUM;
                    end
                end
                swsd_pkg::S_VAR: begin
                    // read -> square -> accumulate, one sample a cycle
                    if (w_idx_live) begin
                        r_idx <= r_idx + IW'(1);
                    end
                    r_rdv <= w_idx_live;
                    r_pv  <= r_rdv;
                    if (r_pv) begin
                        r_acc <= r_acc + w_prod[DW-1:0];
                    end
                    if (!w_idx_live && !r_rdv && !r_pv) begin
                        r_x  <= r_acc;
                        r_dk <= swsd_pkg::DIV_VAR;
                    end
                end
                swsd_pkg::S_CMP: begin
                    if (w_stable) begin
                        r_st    <= swsd_pkg::ST_STABLE;
                        r_count <= '0;
                        r_wptr  <= '0;
                    end else begin
                        r_st <= swsd_pkg::ST_UNSTABLE;
                    end
                end
                swsd_pkg::S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_st;
                        r_out_mean   <= r_mean;
                        r_out_var    <= r_var;
                        r_out_cnt    <= r_cnt_out;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_mean_us       = r_out_mean;
    assign o_variance_us2  = r_out_var;
    assign o_samples_taken = r_out_cnt;

    // ---------------------------------------------------------------- assertions
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != swsd_pkg::S_IDLE))
        else $error("sequencer still idle after an input transfer");

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= PTR_LAST)
        else $error("ring write pointer beyond window");

    a_collect_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == swsd_pkg::ST_COLLECTING) |->
        (o_samples_taken < CNT_WIN && o_mean_us == '0 && o_variance_us2 == '0))
        else $error("collecting result with full window or non-zero statistics");

    a_stable_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swsd_pkg::S_CMP && w_stable) |=> (r_count == '0 && r_wptr == '0))
        else $error("stable result did not clear the sample count");

endmodule
